[design/imm_pkg.sv]
// Shared constants, helper functions and controller/datapath interface types for the matrix unit.
package imm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int CFG_W   = 4;
    localparam int CNT_W   = 8;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS_A = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_B = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd3;

    // Result status codes.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    // Effective dimension: zero acts as one, anything above the maximum is clamped.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic              first;
        logic              last_k;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              mismatch;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic busy;
    } t_dp_status;

endpackage

[design/imm_datapath.sv]
// Datapath: operand memories, shared multiply-accumulate pipeline and output register.
module imm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  imm_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [imm_pkg::DATA_W-1:0]    i_element,
    input  logic                                 i_stall,
    output imm_pkg::t_dp_status                  o_status,
    output logic                                 o_valid,
    output logic signed [imm_pkg::DATA_W-1:0]    o_product_value,
    output logic [imm_pkg::IDX_W-1:0]            o_row_index,
    output logic [imm_pkg::IDX_W-1:0]            o_col_index,
    output logic                                 o_last,
    output logic                                 o_status_bit
);
    import imm_pkg::*;

    logic [DATA_W-1:0] store_a [DEPTH];
    logic [DATA_W-1:0] store_b [DEPTH];

    logic [DATA_W-1:0] r_rd_a, r_rd_b;
    logic              r_v1, r_first1, r_last1;
    logic [DATA_W-1:0] r_prod;
    logic              r_v2, r_first2, r_last2;
    logic [DATA_W-1:0] r_acc;
    logic              r_acc_done;
    logic [IDX_W-1:0]  r_tag_row, r_tag_col;
    logic              r_tag_last;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [IDX_W-1:0]  r_out_row, r_out_col;
    logic              r_out_last, r_out_status;

    logic [2*DATA_W-1:0] full_prod;
    logic                out_free;
    logic                move;

    assign full_prod = r_rd_a * r_rd_b;
    assign out_free  = !r_out_valid || !i_stall;
    assign move      = r_acc_done && out_free;

    // Memories and the read stage.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            store_a[i_cmd.wr_addr] <= i_element;
        end
        if (i_cmd.wr_b) begin
            store_b[i_cmd.wr_addr] <= i_element;
        end
        if (i_cmd.issue) begin
            r_rd_a <= store_a[i_cmd.rd_addr_a];
            r_rd_b <= store_b[i_cmd.rd_addr_b];
        end
    end

    // Payload registers of the pipeline and output word.
    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last_k;
        r_prod   <= full_prod[DATA_W-1:0];
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        if (r_v2) begin
            r_acc <= r_first2 ? r_prod : r_acc + r_prod;
        end
        if (i_cmd.issue && i_cmd.first) begin
            r_tag_row  <= i_cmd.row;
            r_tag_col  <= i_cmd.col;
            r_tag_last <= i_cmd.last;
        end
        if (i_cmd.mismatch) begin
            r_out_value  <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= STATUS_MISMATCH;
        end else if (move) begin
            r_out_value  <= r_acc;
            r_out_row    <= r_tag_row;
            r_out_col    <= r_tag_col;
            r_out_last   <= r_tag_last;
            r_out_status <= STATUS_OK;
        end
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (r_v2 && r_last2) begin
                r_acc_done <= 1'b1;
            end else if (move) begin
                r_acc_done <= 1'b0;
            end
            if (i_cmd.mismatch || move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = out_free;
    assign o_status.busy     = r_v1 || r_v2 || r_acc_done;

    assign o_valid         = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_row_index     = r_out_row;
    assign o_col_index     = r_out_col;
    assign o_last          = r_out_last;
    assign o_status_bit    = r_out_status;

endmodule

[design/imm_ctrl.sv]
// Controller: configuration registers, load counter and the sequencer of the multiply loops.
module imm_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]          i_cfg_data,
    input  imm_pkg::t_dp_status                i_status,
    output imm_pkg::t_dp_cmd                   o_cmd
);
    import imm_pkg::*;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [CFG_W-1:0]  n_rows_a, n_cols_a, n_rows_b, n_cols_b;
    logic [CNT_W-1:0]  r_lc, n_lc;
    logic [IDX_W-1:0]  r_i, r_j, r_k, n_i, n_j, n_k;
    logic [ADDR_W-1:0] r_a_base, r_a_addr, r_b_addr;
    logic [ADDR_W-1:0] n_a_base, n_a_addr, n_b_addr;

    logic [CFG_W-1:0]  ra, ca, cb;
    logic [CNT_W-1:0]  na, nb, nab, lc_eff, lc_inc;
    logic              mismatch, accept;
    logic              k_last, j_last, i_last;

    always_comb begin
        ra       = eff_dim(r_rows_a);
        ca       = eff_dim(r_cols_a);
        cb       = eff_dim(r_cols_b);
        na       = CNT_W'(ra) * CNT_W'(ca);
        nb       = CNT_W'(ca) * CNT_W'(cb);
        nab      = na + nb;
        lc_eff   = (r_lc >= nab) ? '0 : r_lc;
        lc_inc   = lc_eff + CNT_W'(1);
        mismatch = (r_cols_a != r_rows_b);
        k_last   = (CFG_W'(r_k) == ca - CFG_W'(1));
        j_last   = (CFG_W'(r_j) == cb - CFG_W'(1));
        i_last   = (CFG_W'(r_i) == ra - CFG_W'(1));
    end

    always_comb begin
        unique case (r_state)
            S_LOAD:  o_stall = mismatch ? !i_status.out_free : 1'b0;
            default: o_stall = 1'b1;
        endcase
    end

    assign accept = i_valid && !o_stall;

    always_comb begin
        n_state  = r_state;
        n_rows_a = r_rows_a;
        n_cols_a = r_cols_a;
        n_rows_b = r_rows_b;
        n_cols_b = r_cols_b;
        n_lc     = r_lc;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a_base = r_a_base;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        o_cmd    = '0;

        o_cmd.rd_addr_a = r_a_addr;
        o_cmd.rd_addr_b = r_b_addr;
        o_cmd.row       = r_i;
        o_cmd.col       = r_j;
        o_cmd.last      = i_last && j_last;
        o_cmd.first     = (r_k == '0);
        o_cmd.last_k    = k_last;

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (mismatch) begin
                        o_cmd.mismatch = 1'b1;
                    end else begin
                        if (lc_eff < na) begin
                            o_cmd.wr_a    = 1'b1;
                            o_cmd.wr_addr = ADDR_W'(lc_eff);
                        end else begin
                            o_cmd.wr_b    = 1'b1;
                            o_cmd.wr_addr = ADDR_W'(lc_eff - na);
                        end
                        if (lc_inc == nab) begin
                            n_lc     = '0;
                            n_i      = '0;
                            n_j      = '0;
                            n_k      = '0;
                            n_a_base = '0;
                            n_a_addr = '0;
                            n_b_addr = '0;
                            n_state  = S_ISSUE;
                        end else begin
                            n_lc = lc_inc;
                        end
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_a_addr    = r_a_addr + ADDR_W'(1);
                n_b_addr    = r_b_addr + ADDR_W'(cb);
                n_k         = r_k + IDX_W'(1);
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_status.busy) begin
                    if (i_last && j_last) begin
                        n_state = S_LOAD;
                    end else if (j_last) begin
                        n_j      = '0;
                        n_i      = r_i + IDX_W'(1);
                        n_a_base = r_a_base + ADDR_W'(ca);
                        n_a_addr = r_a_base + ADDR_W'(ca);
                        n_b_addr = '0;
                        n_state  = S_ISSUE;
                    end else begin
                        n_j      = r_j + IDX_W'(1);
                        n_a_addr = r_a_base;
                        n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
                        n_state  = S_ISSUE;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // Any register write restarts loading.
        if (i_cfg_we) begin
            n_lc = '0;
            unique case (i_cfg_index)
                REG_ROWS_A: n_rows_a = i_cfg_data;
                REG_COLS_A: n_cols_a = i_cfg_data;
                REG_ROWS_B: n_rows_b = i_cfg_data;
                REG_COLS_B: n_cols_b = i_cfg_data;
                default:    n_lc = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_rows_a <= CFG_W'(1);
            r_cols_a <= CFG_W'(1);
            r_rows_b <= CFG_W'(1);
            r_cols_b <= CFG_W'(1);
            r_lc     <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else begin
            r_state  <= n_state;
            r_rows_a <= n_rows_a;
            r_cols_a <= n_cols_a;
            r_rows_b <= n_rows_b;
            r_cols_b <= n_cols_b;
            r_lc     <= n_lc;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_a_base <= n_a_base;
            r_a_addr <= n_a_addr;
            r_b_addr <= n_b_addr;
        end
    end

endmodule

[design/integer_matrix_multiply_unit.sv]
// Integer matrix multiply unit: top level joining controller and datapath.
// Loading takes one element word per cycle in the load state; the word that completes
// B starts the multiply. Each C word then runs on the single shared multiply-accumulate:
// one operand read pair per inner-product step, then three pipeline stages and a hand-off.
// Mismatch words come back one per input word, each in the cycle after it is taken.
// Synchronous active-low reset sets all four dimensions to 1 and empties the load.
module integer_matrix_multiply_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [imm_pkg::DATA_W-1:0]  i_element,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [imm_pkg::DATA_W-1:0]  o_product_value,
    output logic [imm_pkg::IDX_W-1:0]          o_row_index,
    output logic [imm_pkg::IDX_W-1:0]          o_col_index,
    output logic                               o_last,
    output logic                               o_status,
    input  logic                               i_cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]          i_cfg_data
);
    import imm_pkg::*;

    // Command and status between the sequencer and the arithmetic.
    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns the dimension registers and the load count, and walks the
    // row, column and inner-product loops, issuing one pair of operand reads per cycle in its issue state.
    imm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds both operand stores, the registered read, the multiplier, the
    // accumulator and the output word register, which frees the input side while a
    // finished word waits downstream.
    imm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_element       (i_element),
        .i_stall         (i_stall),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_last          (o_last),
        .o_status_bit    (o_status)
    );

endmodule

[verif/integer_matrix_multiply_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the matrix unit: tracks dimensions, predicts C words and compares results.
module integer_matrix_multiply_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic signed [imm_pkg::DATA_W-1:0]  i_element,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [imm_pkg::DATA_W-1:0]  i_product_value,
    input  logic [imm_pkg::IDX_W-1:0]          i_row_index,
    input  logic [imm_pkg::IDX_W-1:0]          i_col_index,
    input  logic                               i_last,
    input  logic                               i_status,
    input  logic                               i_cfg_we,
    input  logic [imm_pkg::REG_IDX_W-1:0]      i_cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]          i_cfg_data,
    output int                                 o_error_count,
    output int                                 o_pending
);

    typedef struct packed {
        logic signed [imm_pkg::DATA_W-1:0] value;
        logic [imm_pkg::IDX_W-1:0]         row;
        logic [imm_pkg::IDX_W-1:0]         col;
        logic                              last;
        logic                              status;
    } t_c_word;

    logic [imm_pkg::CFG_W-1:0]  rows_a, cols_a, rows_b, cols_b;
    logic [imm_pkg::DATA_W-1:0] a_elems [imm_pkg::DEPTH];
    logic [imm_pkg::DATA_W-1:0] b_elems [imm_pkg::DEPTH];
    int                         loaded;
    t_c_word                    expected_words [$];

    // A programmed size of zero counts as one; anything above the array limit is clamped.
    function automatic int clamp_dim(input logic [imm_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > imm_pkg::MAX_DIM) begin
            return imm_pkg::MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_error_count++;
        end
    endfunction

    // Store one accepted element; the element that completes B yields all of C.
    task automatic take_element(input logic [imm_pkg::DATA_W-1:0] value);
        int      ra, ca, cb, na, nb;
        logic [imm_pkg::DATA_W-1:0] acc;
        t_c_word w;
        if (cols_a != rows_b) begin
            w.value  = '0;
            w.row    = '0;
            w.col    = '0;
            w.last   = 1'b1;
            w.status = imm_pkg::STATUS_MISMATCH;
            expected_words.push_back(w);
            return;
        end
        ra = clamp_dim(rows_a);
        ca = clamp_dim(cols_a);
        cb = clamp_dim(cols_b);
        na = ra * ca;
        nb = ca * cb;
        if (loaded < na) begin
            a_elems[loaded] = value;
        end else begin
            b_elems[loaded - na] = value;
        end
        loaded++;
        if (loaded < na + nb) begin
            return;
        end
        loaded = 0;
        for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < cb; j++) begin
                acc = '0;
                for (int k = 0; k < ca; k++) begin
                    acc += a_elems[i * ca + k] * b_elems[k * cb + j];
                end
                w.value  = acc;
                w.row    = imm_pkg::IDX_W'(i);
                w.col    = imm_pkg::IDX_W'(j);
                w.last   = (i == ra - 1) && (j == cb - 1);
                w.status = imm_pkg::STATUS_OK;
                expected_words.push_back(w);
            end
        end
    endtask

    task automatic compare_word();
        t_c_word want;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: product_value %0d row %0d col %0d status %0d",
                   i_product_value, i_row_index, i_col_index, i_status);
            o_error_count++;
            return;
        end
        want = expected_words.pop_front();
        check_field("product_value", want.value, i_product_value);
        check_field("row_index", want.row, i_row_index);
        check_field("col_index", want.col, i_col_index);
        check_field("last", want.last, i_last);
        check_field("status", want.status, i_status);
    endtask

    // Results are compared before the input word of the same edge is taken, so a
    // word can never be matched against an element that arrived in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a = 4'd1;
            cols_a = 4'd1;
            rows_b = 4'd1;
            cols_b = 4'd1;
            loaded = 0;
            o_error_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    imm_pkg::REG_ROWS_A: rows_a = i_cfg_data;
                    imm_pkg::REG_COLS_A: cols_a = i_cfg_data;
                    imm_pkg::REG_ROWS_B: rows_b = i_cfg_data;
                    imm_pkg::REG_COLS_B: cols_b = i_cfg_data;
                    default: ;
                endcase
                loaded = 0;
            end
            if (i_out_valid && !i_out_stall) begin
                compare_word();
            end
            if (i_in_valid && !i_in_stall) begin
                take_element(i_element);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[verif/integer_matrix_multiply_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the matrix unit testbench: clock, reset, element and register stimulus, verdict.
module integer_matrix_multiply_unit_tb;

    import imm_pkg::*;

    // Cycles allowed after the last expected word before registers change or the run
    // ends, enough to cover any trailing work of the unit.
    localparam int SETTLE_CYCLES = 16;
    // Length of the long receiver hold-off used to back the unit up.
    localparam int HOLD_CYCLES   = 300;
    // Far above the slowest legal run of this stimulus.
    localparam int CYCLE_LIMIT   = 400000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [DATA_W-1:0]   i_element = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [DATA_W-1:0]   o_product_value;
    logic [IDX_W-1:0]           o_row_index;
    logic [IDX_W-1:0]           o_col_index;
    logic                       o_last;
    logic                       o_status;
    logic                       i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    int error_count;
    int pending_words;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;

    integer_matrix_multiply_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element       (i_element),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_last          (o_last),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    integer_matrix_multiply_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_element       (i_element),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_product_value (o_product_value),
        .i_row_index     (o_row_index),
        .i_col_index     (o_col_index),
        .i_last          (o_last),
        .i_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_pending       (pending_words)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver side. Each bump of hold_requests starts one long hold-off, counted here,
    // during which the unit has to buffer results and eventually push back on its input.
    // Otherwise the stall is random at the rate of the current phase.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Element values lean on the 32-bit corners so products and sums wrap often.
    function automatic logic [DATA_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7fff_ffff;
            end
            2: begin
                return 32'hffff_ffff;
            end
            3: begin
                return 32'(int'($urandom_range(0, 15)));
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Size the unit actually uses for a programmed dimension.
    function automatic int dim_used(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // Offer one element word and hold it until the unit takes it. Random idle cycles
    // go in front of the word at the current sender rate.
    task automatic drive_word(input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // Withdraw the sender and wait until every predicted word has been received.
    task automatic drain_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Program all four dimensions. Called only with the unit idle: nothing pending and
    // a settle gap so that a half-finished load has no element still in flight.
    task automatic configure_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                                  input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
        drain_input();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROWS_A;
        i_cfg_data  <= ra;
        @(negedge i_clk);
        i_cfg_index <= REG_COLS_A;
        i_cfg_data  <= ca;
        @(negedge i_clk);
        i_cfg_index <= REG_ROWS_B;
        i_cfg_data  <= rb;
        @(negedge i_clk);
        i_cfg_index <= REG_COLS_B;
        i_cfg_data  <= cb;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One job: program the sizes, then stream 'loads' complete A/B pairs with the same
    // sizes. With a dimension mismatch every word is rejected, so the count is just a
    // burst length. cut_short drops the tail of the last load, leaving it for the next
    // register write to abandon. hold_output starts a receiver hold-off with the job.
    task automatic run_job(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                           input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb,
                           input int loads, input bit cut_short, input bit hold_output,
                           output int sent);
        int per_load;
        int count;
        configure_dims(ra, ca, rb, cb);
        if (ca != rb) begin
            per_load = hold_output ? 12 : $urandom_range(3, 8);
        end else begin
            per_load = dim_used(ra) * dim_used(ca) + dim_used(ca) * dim_used(cb);
        end
        count = loads * per_load;
        if (cut_short && ca == rb && per_load > 1) begin
            count -= $urandom_range(1, per_load - 1);
        end
        if (hold_output) begin
            hold_requests++;
        end
        for (int n = 0; n < count; n++) begin
            // Now and then the sender waits for the whole product before the next load.
            if (n > 0 && n % per_load == 0 && $urandom_range(0, 3) == 0) begin
                drain_input();
            end
            drive_word(pick_element());
        end
        drain_input();
        sent = count;
    endtask

    // Random sizes: mostly small matched shapes, sometimes a long inner dimension,
    // register values outside the legal range, or a mismatch between cols_a and rows_b.
    task automatic run_random_job(output int sent);
        logic [CFG_W-1:0] ra, ca, rb, cb;
        int pick;
        pick = $urandom_range(0, 9);
        ra   = CFG_W'($urandom_range(1, 3));
        ca   = CFG_W'($urandom_range(1, 3));
        cb   = CFG_W'($urandom_range(1, 3));
        rb   = ca;
        if (pick == 0) begin
            // Flip one bit so the raw values differ, e.g. 8 against 9, which both clamp
            // to the same size but must still be rejected.
            ra = CFG_W'($urandom_range(0, 15));
            ca = CFG_W'($urandom_range(0, 15));
            cb = CFG_W'($urandom_range(0, 15));
            rb = ca ^ (CFG_W'(1) << $urandom_range(0, 3));
        end else if (pick == 1) begin
            ra = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            ca = 4'd0;
            rb = 4'd0;
            cb = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
        end else if (pick == 2) begin
            ra = 4'd1;
            ca = CFG_W'($urandom_range(4, 8));
            rb = ca;
            cb = 4'd1;
        end
        run_job(ra, ca, rb, cb, 1, $urandom_range(0, 5) == 0, 1'b0, sent);
    endtask

    initial begin
        logic [DATA_W-1:0] corner_words [6];
        int                sent;
        int                phase_items;

        corner_words = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                         32'hffff_ffff, 32'h0000_0001};

        // Reset, released on a falling edge.
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The reset sizes are 1x1 by 1x1, so each pair of words is one
        // product: most negative squared wraps to zero, most positive squared to one,
        // and minus one times one.
        foreach (corner_words[n]) begin
            drive_word(corner_words[n]);
        end
        // cols_a differs from rows_b: every word comes back as a rejection.
        run_job(4'd1, 4'd2, 4'd3, 4'd1, 1, 1'b0, 1'b0, sent);
        // All sizes zero behave as one.
        run_job(4'd0, 4'd0, 4'd0, 4'd0, 1, 1'b0, 1'b0, sent);
        // A 1x8 row times an 8x1 column, reached through zero and oversized values.
        run_job(4'd0, 4'd15, 4'd15, 4'd0, 1, 1'b0, 1'b0, sent);

        // Random part in four idling phases of roughly equal length.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default: begin
                    send_idle_pct = 16;
                    stall_pct     = 16;
                end
            endcase
            if (phase == 0) begin
                // Back-pressure: a burst of rejected words and then two small
                // products, both while the receiver holds off for a long stretch.
                run_job(4'd2, 4'd3, 4'd2, 4'd2, 1, 1'b0, 1'b1, sent);
                run_job(4'd2, 4'd2, 4'd2, 4'd2, 2, 1'b0, 1'b1, sent);
            end
            if (phase == 2) begin
                // An 8x1 column times a 1x8 row once, through clamped register values,
                // so the row and column indexes run all the way to seven and a single
                // element releases the largest burst of C words.
                run_job(4'd15, 4'd1, 4'd1, 4'd9, 1, 1'b0, 1'b0, sent);
            end
            phase_items = 0;
            while (phase_items < 8) begin
                run_random_job(sent);
                phase_items += sent;
            end
        end

        drain_input();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
